FILE: rtl/bba_pkg.sv
// bba_pkg: types and constants for the bitmap block allocator
// no dependencies; imported by bitmap_block_allocator_unit
package bba_pkg;

  localparam int ADDR_W  = 48;
  localparam int SIZE_W  = 32;
  localparam int BSIZE_W = 21;
  localparam int COUNT_W = 11;
  localparam int ALIGN_W = 4;
  localparam int FIRST_W = 10;
  localparam int STAT_W  = 2;
  localparam int DIVC_W  = 5;

  localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [SIZE_W-1:0]  size_bytes;
    logic [ALIGN_W-1:0] align_log2;
    logic [ADDR_W-1:0]  address;
  } bba_in_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ADDR_W-1:0]  result_address;
    logic [FIRST_W-1:0] first_block;
    logic [COUNT_W-1:0] blocks_touched;
  } bba_out_t;

endpackage

FILE: rtl/bitmap_block_allocator_unit.sv
// bitmap_block_allocator_unit: first-fit allocator over a used-bit map of equal blocks
// depends on bba_pkg; the bit map is a one-bit memory inside this module
// After reset the map is cleared one entry a cycle, with busy high.
// An item is taken when start is high and busy low; its result appears on result for one
// cycle with done high, and must be captured then. Every item of nonzero size, with a
// nonzero block size, runs through one shared 32-step restoring divider for the block
// count of its size. An allocate then scans the map, reading then checking each block,
// up to the end of the fitting run and marks the run at one block a cycle. A free adds
// a multiply, a range check and a second division for its first block, then clears one
// block a cycle. A zero size or zero block size is answered with ST_BAD from idle.
module bitmap_block_allocator_unit
  import bba_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bba_in_t        in_item,
  output logic           done,
  output bba_out_t       result,
  input  logic           cfg_write,
  input  logic [1:0]     cfg_index,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int AW = (IW > COUNT_W) ? IW : COUNT_W;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_DIVS     = 12'b000000000100,
    S_CHKS     = 12'b000000001000,
    S_SCAN_RD  = 12'b000000010000,
    S_SCAN_CHK = 12'b000000100000,
    S_MARK     = 12'b000001000000,
    S_MUL      = 12'b000010000000,
    S_RANGE    = 12'b000100000000,
    S_DIVA     = 12'b001000000000,
    S_CLAMP    = 12'b010000000000,
    S_UNMARK   = 12'b100000000000
  } state_t;

  state_t state;

  logic [ADDR_W-1:0]  base_address;
  logic [BSIZE_W-1:0] block_size;
  logic [COUNT_W-1:0] block_count;
  logic [COUNT_W-1:0] count_eff;

  bba_in_t            item;
  logic [SIZE_W-1:0]  div_q;
  logic [BSIZE_W-1:0] div_r;
  logic [DIVC_W-1:0]  div_cnt;
  logic [BSIZE_W:0]   div_tr;
  logic               div_ge;
  logic [SIZE_W-1:0]  q_size;
  logic [SIZE_W-1:0]  prod;
  logic [COUNT_W-1:0] nblk;
  logic [COUNT_W-1:0] run;
  logic [COUNT_W-1:0] run_n;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      start_idx;
  logic [AW-1:0]      wr_end;
  logic [ADDR_W-1:0]  acc;
  logic [ADDR_W-1:0]  start_acc;
  logic [15:0]        amask;
  logic               aligned;
  logic               blk_used;
  logic [IW-1:0]      clr_idx;
  logic [COUNT_W-1:0] lim;
  logic [COUNT_W-1:0] touched;
  logic [ADDR_W:0]    pool_end;
  logic [ADDR_W:0]    diff;

  logic               mem [MAX_BLOCKS];
  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic               mem_wd;
  logic               rd_data;

  assign count_eff = (32'(block_count) > 32'(MAX_BLOCKS)) ? COUNT_W'(MAX_BLOCKS) : block_count;
  assign busy      = (state != S_IDLE);
  assign div_tr    = {div_r, div_q[SIZE_W-1]};
  assign div_ge    = (div_tr >= {1'b0, block_size});
  assign amask     = 16'((17'd1 << item.align_log2) - 17'd1);
  assign aligned   = ((acc[15:0] & amask) == 16'd0);
  assign blk_used  = rd_data;
  assign pool_end  = {1'b0, base_address} + (ADDR_W+1)'(prod);
  assign diff      = {1'b0, item.address} - {1'b0, base_address};
  assign lim       = count_eff - COUNT_W'(div_q);
  assign touched   = (q_size >= SIZE_W'(lim)) ? lim : COUNT_W'(q_size) + COUNT_W'(1);

  always_comb begin
    if (blk_used) begin
      run_n = '0;
    end else if (run == '0) begin
      run_n = aligned ? COUNT_W'(1) : '0;
    end else begin
      run_n = run + COUNT_W'(1);
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = clr_idx;
    mem_wd = 1'b0;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_MARK: begin
        mem_we = 1'b1;
        mem_wa = idx[IW-1:0];
        mem_wd = 1'b1;
      end
      S_UNMARK: begin
        mem_we = 1'b1;
        mem_wa = idx[IW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
      block_size   <= BSIZE_W'(64);
      block_count  <= COUNT_W'(1024);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_BLOCK_SIZE:   block_size   <= cfg_data[BSIZE_W-1:0];
        REG_BLOCK_COUNT:  block_count  <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + IW'(1);
          if (clr_idx == IW'(MAX_BLOCKS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            item <= in_item;
            if (in_item.size_bytes == '0 || block_size == '0) begin
              result <= '{ST_BAD, '0, '0, '0};
              done   <= 1'b1;
            end else begin
              div_q   <= in_item.size_bytes - SIZE_W'(1);
              div_r   <= '0;
              div_cnt <= '0;
              state   <= S_DIVS;
            end
          end
        end
        S_DIVS, S_DIVA: begin
          div_r   <= div_ge ? BSIZE_W'(div_tr - {1'b0, block_size}) : div_tr[BSIZE_W-1:0];
          div_q   <= {div_q[SIZE_W-2:0], div_ge};
          div_cnt <= div_cnt + DIVC_W'(1);
          if (div_cnt == '1) begin
            state <= (state == S_DIVS) ? S_CHKS : S_CLAMP;
          end
        end
        S_CHKS: begin
          q_size <= div_q;
          if (item.kind == KIND_FREE) begin
            state <= S_MUL;
          end else if (div_q >= SIZE_W'(count_eff)) begin
            result <= '{ST_NOFIT, '0, '0, '0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            nblk  <= COUNT_W'(div_q) + COUNT_W'(1);
            idx   <= '0;
            acc   <= base_address;
            run   <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          run <= run_n;
          if (!blk_used && run == '0 && aligned) begin
            start_idx <= idx;
            start_acc <= acc;
          end
          if (run_n == nblk) begin
            if (run == '0) begin
              idx    <= idx;
              wr_end <= idx + AW'(nblk);
            end else begin
              idx    <= start_idx;
              wr_end <= start_idx + AW'(nblk);
            end
            state <= S_MARK;
          end else if (idx + AW'(1) >= AW'(count_eff)) begin
            result <= '{ST_NOFIT, '0, '0, '0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            idx   <= idx + AW'(1);
            acc   <= acc + ADDR_W'(block_size);
            state <= S_SCAN_RD;
          end
        end
        S_MARK: begin
          idx <= idx + AW'(1);
          if (idx + AW'(1) == wr_end) begin
            result <= '{ST_OK, start_acc, FIRST_W'(start_idx), nblk};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= SIZE_W'(count_eff) * SIZE_W'(block_size);
          state <= S_RANGE;
        end
        S_RANGE: begin
          if (diff[ADDR_W] || {1'b0, item.address} >= pool_end) begin
            result <= '{ST_BAD, '0, '0, '0};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            div_q   <= diff[SIZE_W-1:0];
            div_r   <= '0;
            div_cnt <= '0;
            state   <= S_DIVA;
          end
        end
        S_CLAMP: begin
          idx       <= AW'(div_q);
          start_idx <= AW'(div_q);
          wr_end    <= AW'(div_q) + AW'(touched);
          nblk      <= touched;
          state     <= S_UNMARK;
        end
        S_UNMARK: begin
          idx <= idx + AW'(1);
          if (idx + AW'(1) == wr_end) begin
            result <= '{ST_OK, '0, FIRST_W'(start_idx), nblk};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_ok_touches: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_OK |-> result.blocks_touched != '0)
    else $error("ok result touched no blocks");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status == ST_OK || result.status == ST_NOFIT || result.status == ST_BAD)
    else $error("bad status code");
  a_idle_done: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still working");

endmodule
